>>> rtl/core/stot_pkg.sv
// shared widths and constants for the square/triangle overlap test
package stot_pkg;

  localparam int CRD_W       = 16;
  localparam int SIDE_W      = 14;
  localparam int DIF_W       = CRD_W + 1;
  localparam int SPAN_W      = SIDE_W + 1;
  localparam int PROD_W      = 2 * DIF_W;
  localparam int SPROD_W     = SPAN_W + DIF_W;
  localparam int ACC_W       = 40;
  localparam int PIXEL_SHIFT = 4;
  localparam int CORNERS     = 3;

  localparam int BASE_POINTS_DEF = 32;

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(512);

endpackage

>>> rtl/core/square_triangle_overlap_test.sv
// square/triangle overlap test, five-stage pipeline with one lane per tested point
//
// Usage: the input channel takes the square corner and the three triangle
// vertices as one item (in_valid_i / in_stall_o); the output channel returns
// one hit bit per item (out_valid_o / out_stall_i), in order.
// The square side is held in a register written through cfg_we_i and
// cfg_wdata_i; write it only while no item is in flight.
// One item is taken every cycle unless in_stall_o is high: the corners and
// all BASE_POINTS top-edge points are tested in parallel lanes, each offset
// from a shared base numerator (top-edge lanes by a constant multiple of a
// per-item step, other corners by offsets); more lanes do not slow intake.
// Stages: edge differences, products, numerators and offsets, per-point
// numerators, compare and reduce into the output register.
// Reset clears all stage valid bits and loads the side register with 512.
// When the receiver stalls, the output item holds and empty stages upstream
// still fill; the input stalls only once every stage holds an item.
module square_triangle_overlap_test #(
  parameter int BASE_POINTS = stot_pkg::BASE_POINTS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [stot_pkg::SIDE_W-1:0]   cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [stot_pkg::CRD_W-1:0]    square_x_i,
  input  logic signed [stot_pkg::CRD_W-1:0]    square_y_i,
  input  logic signed [stot_pkg::CRD_W-1:0]    vertex_a_x_i,
  input  logic signed [stot_pkg::CRD_W-1:0]    vertex_a_y_i,
  input  logic signed [stot_pkg::CRD_W-1:0]    vertex_b_x_i,
  input  logic signed [stot_pkg::CRD_W-1:0]    vertex_b_y_i,
  input  logic signed [stot_pkg::CRD_W-1:0]    vertex_c_x_i,
  input  logic signed [stot_pkg::CRD_W-1:0]    vertex_c_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 hit_o
);
  import stot_pkg::*;

  localparam int NPTS = BASE_POINTS + CORNERS;

  logic [SIDE_W-1:0] side_q;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // stage 1: differences
  logic signed [DIF_W-1:0]  e1x_q, e1y_q, e2x_q, e2y_q, qx_q, qy_q;
  logic signed [SPAN_W-1:0] s1_q;

  // stage 2: products
  logic signed [PROD_W-1:0]  p_qx_e2y_q, p_qy_e2x_q, p_e1x_qy_q, p_e1y_qx_q;
  logic signed [PROD_W-1:0]  p_e1x_e2y_q, p_e1y_e2x_q;
  logic signed [SPROD_W-1:0] p_s_e2y_q, p_s_e1y_q, p_s_e2x_q, p_s_e1x_q;
  logic signed [DIF_W-1:0]   e1y2_q, e2y2_q;

  // stage 3: base numerators, corner offsets, lane steps
  logic signed [ACC_W-1:0] nu0_q, nv0_q, d3_q, stepu_q, stepv_q;
  logic signed [ACC_W-1:0] du_q [CORNERS];
  logic signed [ACC_W-1:0] dv_q [CORNERS];

  // stage 4: per-point numerators
  logic signed [ACC_W-1:0] nu4_d [NPTS];
  logic signed [ACC_W-1:0] nv4_d [NPTS];
  logic signed [ACC_W-1:0] nu4_q [NPTS];
  logic signed [ACC_W-1:0] nv4_q [NPTS];
  logic signed [ACC_W-1:0] d4_q;
  logic                    dpos4_q, dneg4_q;

  // stage 5: compare and reduce
  logic [NPTS-1:0] in_pt;
  logic            hit_d, hit_q;

  // handshake: a stage takes a new item when empty or when it moves on
  assign rdy5       = !v5_q || !out_stall_i;
  assign rdy4       = !v4_q || rdy5;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SIDE_RESET;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        side_q <= cfg_wdata_i;
      end
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      e1x_q <= DIF_W'(vertex_b_x_i) - DIF_W'(vertex_a_x_i);
      e1y_q <= DIF_W'(vertex_b_y_i) - DIF_W'(vertex_a_y_i);
      e2x_q <= DIF_W'(vertex_c_x_i) - DIF_W'(vertex_a_x_i);
      e2y_q <= DIF_W'(vertex_c_y_i) - DIF_W'(vertex_a_y_i);
      qx_q  <= DIF_W'(square_x_i) - DIF_W'(vertex_a_x_i);
      qy_q  <= DIF_W'(square_y_i) - DIF_W'(vertex_a_y_i);
      s1_q  <= $signed({1'b0, side_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      p_qx_e2y_q  <= PROD_W'(qx_q) * PROD_W'(e2y_q);
      p_qy_e2x_q  <= PROD_W'(qy_q) * PROD_W'(e2x_q);
      p_e1x_qy_q  <= PROD_W'(e1x_q) * PROD_W'(qy_q);
      p_e1y_qx_q  <= PROD_W'(e1y_q) * PROD_W'(qx_q);
      p_e1x_e2y_q <= PROD_W'(e1x_q) * PROD_W'(e2y_q);
      p_e1y_e2x_q <= PROD_W'(e1y_q) * PROD_W'(e2x_q);
      p_s_e2y_q   <= SPROD_W'(s1_q) * SPROD_W'(e2y_q);
      p_s_e1y_q   <= SPROD_W'(s1_q) * SPROD_W'(e1y_q);
      p_s_e2x_q   <= SPROD_W'(s1_q) * SPROD_W'(e2x_q);
      p_s_e1x_q   <= SPROD_W'(s1_q) * SPROD_W'(e1x_q);
      e1y2_q      <= e1y_q;
      e2y2_q      <= e2y_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      nu0_q   <= ACC_W'(p_qx_e2y_q) - ACC_W'(p_qy_e2x_q);
      nv0_q   <= ACC_W'(p_e1x_qy_q) - ACC_W'(p_e1y_qx_q);
      d3_q    <= ACC_W'(p_e1x_e2y_q) - ACC_W'(p_e1y_e2x_q);
      stepu_q <= ACC_W'(e2y2_q) <<< PIXEL_SHIFT;
      stepv_q <= -(ACC_W'(e1y2_q) <<< PIXEL_SHIFT);
      // corners (x+s,y), (x,y+s), (x+s,y+s)
      du_q[0] <= ACC_W'(p_s_e2y_q);
      dv_q[0] <= -ACC_W'(p_s_e1y_q);
      du_q[1] <= -ACC_W'(p_s_e2x_q);
      dv_q[1] <= ACC_W'(p_s_e1x_q);
      du_q[2] <= ACC_W'(p_s_e2y_q) - ACC_W'(p_s_e2x_q);
      dv_q[2] <= ACC_W'(p_s_e1x_q) - ACC_W'(p_s_e1y_q);
    end
  end

  for (genvar k = 0; k < CORNERS; k++) begin : g_corner
    assign nu4_d[k] = nu0_q + du_q[k];
    assign nv4_d[k] = nv0_q + dv_q[k];
  end

  // top-edge lane zero (index CORNERS) is the square corner itself
  for (genvar i = 0; i < BASE_POINTS; i++) begin : g_lane
    assign nu4_d[CORNERS+i] = nu0_q + $signed(ACC_W'(i)) * stepu_q;
    assign nv4_d[CORNERS+i] = nv0_q + $signed(ACC_W'(i)) * stepv_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      nu4_q   <= nu4_d;
      nv4_q   <= nv4_d;
      d4_q    <= d3_q;
      dpos4_q <= !d3_q[ACC_W-1] && (d3_q != '0);
      dneg4_q <= d3_q[ACC_W-1];
    end
  end

  for (genvar k = 0; k < NPTS; k++) begin : g_test
    logic signed [ACC_W-1:0] sum;
    assign sum = nu4_q[k] + nv4_q[k];
    assign in_pt[k] =
        (dpos4_q && !nu4_q[k][ACC_W-1] && !nv4_q[k][ACC_W-1] && (sum <= d4_q)) ||
        (dneg4_q && (nu4_q[k][ACC_W-1] || (nu4_q[k] == '0)) &&
         (nv4_q[k][ACC_W-1] || (nv4_q[k] == '0)) && (sum >= d4_q));
  end

  assign hit_d = |in_pt;

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      hit_q <= hit_d;
    end
  end

  assign out_valid_o = v5_q;
  assign hit_o       = hit_q;

`ifndef SYNTH
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && v5_q && out_stall_i))
    else $error("input stalled while the pipeline has a free stage");

  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (v4_q && !rdy5) |=> v4_q)
    else $error("item dropped from stage 4 while the output was stalled");

  a_degenerate: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (v4_q && rdy5 && !dpos4_q && !dneg4_q) |=> !hit_o)
    else $error("hit reported for a degenerate triangle");
`endif

endmodule

>>> test/square_triangle_overlap_test_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the square/triangle overlap test block
module square_triangle_overlap_test_tb;
  import stot_pkg::*;

  localparam int N_BASE = BASE_POINTS_DEF;
  localparam int PIXEL = 1 << PIXEL_SHIFT;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 10;
  localparam int MAX_REPORTS = 10;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int PHASES = 6;
  localparam longint CRD_MAX = 32767;
  localparam longint CRD_MIN = -32768;

  typedef struct packed {
    logic signed [CRD_W-1:0] sq_x;
    logic signed [CRD_W-1:0] sq_y;
    logic signed [CRD_W-1:0] ax;
    logic signed [CRD_W-1:0] ay;
    logic signed [CRD_W-1:0] bx;
    logic signed [CRD_W-1:0] by;
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
  } shape_t;

  class overlap_board;
    logic [SIDE_W-1:0] side = SIDE_RESET;
    bit hits_due[$];
    int mismatches = 0;

    function bit point_in(input longint px, py, ax, ay, e1x, e1y, e2x, e2y, det);
      longint qx, qy, nu, nv;
      qx = px - ax;
      qy = py - ay;
      nu = qx * e2y - qy * e2x;
      nv = e1x * qy - e1y * qx;
      if (det > 0) return nu >= 0 && nv >= 0 && nu + nv <= det;
      if (det < 0) return nu <= 0 && nv <= 0 && nu + nv >= det;
      return 1'b0;
    endfunction

    function bit predict_hit(shape_t s);
      longint x, y, sd, ax, ay, e1x, e1y, e2x, e2y, det;
      bit hit;
      x = $signed(s.sq_x);
      y = $signed(s.sq_y);
      sd = side;
      ax = $signed(s.ax);
      ay = $signed(s.ay);
      e1x = longint'($signed(s.bx)) - ax;
      e1y = longint'($signed(s.by)) - ay;
      e2x = longint'($signed(s.cx)) - ax;
      e2y = longint'($signed(s.cy)) - ay;
      det = e1x * e2y - e1y * e2x;
      hit = point_in(x, y, ax, ay, e1x, e1y, e2x, e2y, det) ||
            point_in(x + sd, y, ax, ay, e1x, e1y, e2x, e2y, det) ||
            point_in(x, y + sd, ax, ay, e1x, e1y, e2x, e2y, det) ||
            point_in(x + sd, y + sd, ax, ay, e1x, e1y, e2x, e2y, det);
      for (int i = 0; i < N_BASE; i++)
        hit |= point_in(x + PIXEL * i, y, ax, ay, e1x, e1y, e2x, e2y, det);
      return hit;
    endfunction

    function void note_item(shape_t s);
      hits_due.push_back(predict_hit(s));
    endfunction

    function void check_hit(logic got);
      bit want;
      if (hits_due.size() == 0) begin
        if (mismatches < MAX_REPORTS) $display("unexpected item: hit %b", got);
        mismatches++;
        return;
      end
      want = hits_due.pop_front();
      if (got !== want) begin
        if (mismatches < MAX_REPORTS)
          $display("hit mismatch at %0t: expected %0d, got %b", $realtime, want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [SIDE_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CRD_W-1:0] square_x_i = '0;
  logic signed [CRD_W-1:0] square_y_i = '0;
  logic signed [CRD_W-1:0] vertex_a_x_i = '0;
  logic signed [CRD_W-1:0] vertex_a_y_i = '0;
  logic signed [CRD_W-1:0] vertex_b_x_i = '0;
  logic signed [CRD_W-1:0] vertex_b_y_i = '0;
  logic signed [CRD_W-1:0] vertex_c_x_i = '0;
  logic signed [CRD_W-1:0] vertex_c_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;

  overlap_board board = new;
  int idle_pct = 0;
  int quiet_cycles = 0;

  square_triangle_overlap_test #(
    .BASE_POINTS(N_BASE)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .square_x_i  (square_x_i),
    .square_y_i  (square_y_i),
    .vertex_a_x_i(vertex_a_x_i),
    .vertex_a_y_i(vertex_a_y_i),
    .vertex_b_x_i(vertex_b_x_i),
    .vertex_b_y_i(vertex_b_y_i),
    .vertex_c_x_i(vertex_c_x_i),
    .vertex_c_y_i(vertex_c_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hit_o       (hit_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [CRD_W-1:0] clip(longint v);
    if (v > CRD_MAX) return CRD_MAX[CRD_W-1:0];
    if (v < CRD_MIN) return CRD_MIN[CRD_W-1:0];
    return v[CRD_W-1:0];
  endfunction

  function automatic longint near(longint c, longint r);
    return c - r + longint'($urandom_range(0, int'(2 * r)));
  endfunction

  function automatic logic signed [CRD_W-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return CRD_MIN[CRD_W-1:0];
      1: return CRD_MAX[CRD_W-1:0];
      2: return '0;
      3: return '1;
      default: return CRD_W'($urandom);
    endcase
  endfunction

  function automatic shape_t mk(int x, y, ax, ay, bx, by, cx, cy);
    shape_t s;
    s = '{x[CRD_W-1:0], y[CRD_W-1:0], ax[CRD_W-1:0], ay[CRD_W-1:0],
          bx[CRD_W-1:0], by[CRD_W-1:0], cx[CRD_W-1:0], cy[CRD_W-1:0]};
    return s;
  endfunction

  function automatic shape_t gen_shape(logic [SIDE_W-1:0] side);
    shape_t s;
    longint x, y, sd, ox, oy, r, dx, dy, k, px, py;
    int pick;
    s = shape_t'({$urandom, $urandom, $urandom, $urandom});
    x = $signed(s.sq_x);
    y = $signed(s.sq_y);
    sd = side;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: r = 64;
      1: r = 512;
      2: r = 4096;
      default: r = 16384;
    endcase
    ox = x + longint'($urandom_range(0, int'(sd > 512 ? sd : 512)));
    oy = y + longint'($urandom_range(0, int'(sd)));
    if (pick < 15) begin
      return s;
    end else if (pick < 65) begin
      // triangle scattered around the square
      s.ax = clip(near(ox, r));
      s.ay = clip(near(oy, r));
      s.bx = clip(near(ox, r));
      s.by = clip(near(oy, r));
      s.cx = clip(near(ox, r));
      s.cy = clip(near(oy, r));
    end else if (pick < 77) begin
      // collinear or coincident vertices
      dx = near(0, r);
      dy = near(0, r);
      k = near(0, 3);
      s.ax = clip(ox);
      s.ay = clip(oy);
      s.bx = clip(ox + dx);
      s.by = clip(oy + dy);
      s.cx = clip(ox + k * dx);
      s.cy = clip(oy + k * dy);
    end else if (pick < 89) begin
      // a tested point placed on a vertex or an edge midpoint
      pick = $urandom_range(0, N_BASE + 3);
      px = x + (pick < N_BASE ? PIXEL * pick : ((pick - N_BASE) % 2) * sd);
      py = y + (pick < N_BASE ? 0 : ((pick - N_BASE) / 2) * sd);
      dx = near(0, r);
      dy = near(0, r);
      k = $urandom_range(0, 1);
      s.ax = clip(px - k * dx);
      s.ay = clip(py - k * dy);
      s.bx = clip(px + dx);
      s.by = clip(py + dy);
      s.cx = clip(near(px, r));
      s.cy = clip(near(py, r));
    end else begin
      for (int f = 0; f < 8; f++) s[f*CRD_W +: CRD_W] = pick_extreme();
    end
    return s;
  endfunction

  task automatic send_shape(shape_t s);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {square_x_i, square_y_i, vertex_a_x_i, vertex_a_y_i,
     vertex_b_x_i, vertex_b_y_i, vertex_c_x_i, vertex_c_y_i} <= s;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(s);
  endtask

  task automatic wait_results();
    while (board.hits_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_side(logic [SIDE_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.side = v;
  endtask

  task automatic run_directed();
    send_shape(mk(100, 100, 0, 0, 1000, 0, 0, 1000));
    send_shape(mk(100, 100, 0, 0, 0, 1000, 1000, 0));
    send_shape(mk(-20000, -20000, 0, 0, 1000, 0, 0, 1000));
    send_shape(mk(0, 0, -100, -100, 100, 100, 300, 300));
    send_shape(mk(50, 50, 50, 50, 50, 50, 50, 50));
    send_shape(mk(1000, 0, 0, 0, 1000, 0, 0, 1000));
    send_shape(mk(500, 500, 0, 0, 1000, 0, 0, 1000));
    send_shape(mk(501, 500, 0, 0, 1000, 0, 0, 1000));
    send_shape(mk(0, 0, 70, -10, 90, -10, 80, 10));
    send_shape(mk(0, 0, 486, -10, 506, -10, 496, 10));
    send_shape(mk(0, 0, 500, -8, 508, -8, 504, 8));
    send_shape(mk(0, 0, 502, 502, 522, 502, 512, 522));
    send_shape(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_shape(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_shape(mk(0, 0, -32768, -32768, 32767, -32768, -32768, 32767));
    send_shape(mk(0, 0, -32768, -32768, -32768, 32767, 32767, -32768));
    send_shape(mk(32767, 50, 32767, 0, 32767, 100, 32000, 50));
    // far corners must not wrap around to the negative side
    send_shape(mk(32767, 0, -32300, -50, -32200, -50, -32257, 50));
    send_shape(mk(0, 32767, -50, -32300, 50, -32300, 0, -32200));
    send_shape(mk(-32768, -32768, -32266, -32768, -32246, -32768, -32256, -32748));
    in_valid_i <= 1'b0;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        in_valid_i <= 1'b0;
        wait_results();
      end
      send_shape(gen_shape(board.side));
    end
    in_valid_i <= 1'b0;
  endtask

  // receiver stalls
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_pct != 0 && $urandom_range(1, 400) <= idle_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // result checking and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_hit(hit_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
        $display("** square_triangle_overlap_test: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int phase_idle[PHASES] = '{30, 0, 50, 15, 40, 0};
    logic [SIDE_W-1:0] side;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_pct = 20;
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      wait_results();
      case (p)
        0: side = '1;
        1: side = '0;
        2: side = SIDE_W'(1);
        3: side = SIDE_W'(PIXEL);
        default: side = SIDE_W'($urandom_range(0, (1 << SIDE_W) - 1));
      endcase
      write_side(side);
      idle_pct = phase_idle[p];
      run_random(ITEMS_PER_PHASE);
    end
    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.hits_due.size() == 0) begin
      $display("** square_triangle_overlap_test: PASSED **");
    end else begin
      $display("** square_triangle_overlap_test: FAILED **");
    end
    $finish;
  end

endmodule

>>> square_triangle_overlap_test.f
rtl/core/stot_pkg.sv
rtl/core/square_triangle_overlap_test.sv
test/square_triangle_overlap_test_tb.sv
